// ===== src/point_rotate_about_pivot_top_macros.svh =====
// assertion macros used by the rotate-about-pivot rtl
// expects clk and rst_n in the scope of each use
`ifndef POINT_ROTATE_ABOUT_PIVOT_TOP_MACROS_SVH
`define POINT_ROTATE_ABOUT_PIVOT_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define PRAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PRAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/prap_pkg.sv =====
// shared types, widths and constants for the rotate-about-pivot pipeline
// no dependencies
package prap_pkg;

    localparam int COORD_W             = 32;
    localparam int ANGLE_IN_W          = 16;
    localparam int GUARD               = 8;
    localparam int XW                  = 44;
    localparam int AW                  = 34;
    localparam int MAX_STAGES          = 32;
    localparam int ROTATION_STAGES_DEF = 16;
    localparam int HW                  = XW - 16 + 33;
    localparam int PW                  = HW + 1;
    localparam int RW                  = PW - 16 - GUARD;
    localparam logic [31:0] KGAIN      = 32'd2608131496;

    typedef struct packed {
        logic signed [XW-1:0]      x;
        logic signed [XW-1:0]      y;
        logic signed [AW-1:0]      ang;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] pz;
    } stage_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] rz;
        logic                      clip;
    } res_t;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            30:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/point_rotate_about_pivot_top.sv =====
// top level of the rotate-about-pivot pipeline
// depends on prap_pkg, prap_prep, prap_cell, prap_gain, prap_out
//
// rotates a signed q16.16 point about a pivot by a 16-bit binary angle
// (65536 = full turn). accepts one request per clock and returns one result
// per request, in order. the pipe is one prep stage (offset and quadrant
// fold), ROTATION_STAGES cordic cells (stages above 32 are dropped), three
// gain/round/saturate stages and the result register, ROTATION_STAGES + 5
// registers in all. a result that is stalled parks in a one-entry skid
// buffer; pt_stall is high exactly while that entry is full and the whole
// pipe holds until it drains, so the request side is held while a result
// waits in that entry and takes one request per cycle otherwise.
// clipped flags that either coordinate hit a q16.16 limit.
module point_rotate_about_pivot_top #(
    parameter int ROTATION_STAGES = prap_pkg::ROTATION_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request side
    input  logic                                pt_valid,
    output logic                                pt_stall,
    input  logic signed [prap_pkg::COORD_W-1:0] pivot_x,
    input  logic signed [prap_pkg::COORD_W-1:0] pivot_z,
    input  logic [prap_pkg::ANGLE_IN_W-1:0]     turn_angle,
    input  logic signed [prap_pkg::COORD_W-1:0] point_x,
    input  logic signed [prap_pkg::COORD_W-1:0] point_z,
    // result side
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [prap_pkg::COORD_W-1:0] rotated_x,
    output logic signed [prap_pkg::COORD_W-1:0] rotated_z,
    output logic                                clipped
);
    import prap_pkg::*;

    // cells past the arctangent table would add no angle step
    localparam int NCELL = (ROTATION_STAGES < MAX_STAGES) ? ROTATION_STAGES : MAX_STAGES;

    logic   pipe_en;
    logic   chain_valid [NCELL+1];
    stage_t chain_data  [NCELL+1];
    logic   gain_valid;
    res_t   gain_data;

    // whole pipe moves together; it only halts while the skid entry is full
    assign pt_stall = !pipe_en;

    prap_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (pt_valid),
        .pivot_x    (pivot_x),
        .pivot_z    (pivot_z),
        .turn_angle (turn_angle),
        .point_x    (point_x),
        .point_z    (point_z),
        .out_valid  (chain_valid[0]),
        .out_data   (chain_data[0])
    );

    // chain of micro-rotation cells, cell i shifts by i
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        prap_cell #(
            .STAGE_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // gain compensation, pivot add back and clamp
    prap_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (chain_valid[NCELL]),
        .in_data   (chain_data[NCELL]),
        .out_valid (gain_valid),
        .out_data  (gain_data)
    );

    // result register and skid entry
    prap_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gain_valid),
        .in_data   (gain_data),
        .pipe_en   (pipe_en),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .rotated_x (rotated_x),
        .rotated_z (rotated_z),
        .clipped   (clipped)
    );

endmodule

// ===== src/prap_prep.sv =====
// front stage: offset from pivot, quadrant fold, guard bits
// depends on prap_pkg
module prap_prep (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [prap_pkg::COORD_W-1:0] pivot_x,
    input  logic signed [prap_pkg::COORD_W-1:0] pivot_z,
    input  logic [prap_pkg::ANGLE_IN_W-1:0]     turn_angle,
    input  logic signed [prap_pkg::COORD_W-1:0] point_x,
    input  logic signed [prap_pkg::COORD_W-1:0] point_z,
    output logic                               out_valid,
    output prap_pkg::stage_t                   out_data
);
    import prap_pkg::*;

    logic                      valid_reg;
    stage_t                    data_reg;
    stage_t                    data_next;
    logic                      fold;
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dz;
    logic [ANGLE_IN_W-1:0]     a_fold;

    always_comb
    begin
        fold = turn_angle[15] ^ turn_angle[14];
        // folding negates the offset, so swap the subtraction operands
        if (fold)
        begin
            dx = {pivot_x[COORD_W-1], pivot_x} - {point_x[COORD_W-1], point_x};
            dz = {pivot_z[COORD_W-1], pivot_z} - {point_z[COORD_W-1], point_z};
        end
        else
        begin
            dx = {point_x[COORD_W-1], point_x} - {pivot_x[COORD_W-1], pivot_x};
            dz = {point_z[COORD_W-1], point_z} - {pivot_z[COORD_W-1], pivot_z};
        end
        a_fold       = {turn_angle[15] ^ fold, turn_angle[14:0]};
        data_next.x  = {{(XW-COORD_W-1-GUARD){dx[COORD_W]}}, dx, {GUARD{1'b0}}};
        data_next.y  = {{(XW-COORD_W-1-GUARD){dz[COORD_W]}}, dz, {GUARD{1'b0}}};
        data_next.ang = {{(AW-32){a_fold[15]}}, a_fold, 16'h0000};
        data_next.px = pivot_x;
        data_next.pz = pivot_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/prap_cell.sv =====
// one micro-rotation cell of the rotation chain
// depends on prap_pkg
module prap_cell #(
    parameter int STAGE_IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  prap_pkg::stage_t in_data,
    output logic             out_valid,
    output prap_pkg::stage_t out_data
);
    import prap_pkg::*;

    localparam logic signed [AW-1:0] ATAN_STEP =
        $signed({{(AW-32){1'b0}}, atan_turn(STAGE_IDX)});

    logic                 valid_reg;
    stage_t               data_reg;
    stage_t               data_next;
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [AW-1:0] ang_in;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb
    begin
        x_in   = in_data.x;
        y_in   = in_data.y;
        ang_in = in_data.ang;
        xs     = x_in >>> STAGE_IDX;
        ys     = y_in >>> STAGE_IDX;
        data_next = in_data;
        // residual sign picks the rotation direction
        if (!ang_in[AW-1])
        begin
            data_next.x   = x_in - ys;
            data_next.y   = y_in + xs;
            data_next.ang = ang_in - ATAN_STEP;
        end
        else
        begin
            data_next.x   = x_in + ys;
            data_next.y   = y_in - xs;
            data_next.ang = ang_in + ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/prap_gain.sv =====
// gain compensation, guard-bit rounding, pivot add and saturation
// depends on prap_pkg; three register stages
module prap_gain (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  prap_pkg::stage_t in_data,
    output logic             out_valid,
    output prap_pkg::res_t   out_data
);
    import prap_pkg::*;

    // stage 1: split products
    logic                      v1_reg;
    logic signed [HW-1:0]      hkx_reg;
    logic signed [HW-1:0]      hkz_reg;
    logic [31:0]               lkx_reg;
    logic [31:0]               lkz_reg;
    logic signed [COORD_W-1:0] px1_reg;
    logic signed [COORD_W-1:0] pz1_reg;
    logic signed [HW-1:0]      hkx_next;
    logic signed [HW-1:0]      hkz_next;
    logic [47:0]               lpx;
    logic [47:0]               lpz;
    logic signed [XW-17:0]     hix;
    logic signed [XW-17:0]     hiz;
    logic signed [32:0]        kgain_s;

    // stage 2: sum and round
    logic                      v2_reg;
    logic signed [RW-1:0]      rx_reg;
    logic signed [RW-1:0]      rz_reg;
    logic signed [COORD_W-1:0] px2_reg;
    logic signed [COORD_W-1:0] pz2_reg;
    logic signed [PW-1:0]      psx;
    logic signed [PW-1:0]      psz;
    logic signed [PW-1:0]      rndx;
    logic signed [PW-1:0]      rndz;

    // stage 3: pivot add and clamp
    logic                      v3_reg;
    res_t                      res_reg;
    res_t                      res_next;
    logic signed [RW:0]        sx;
    logic signed [RW:0]        sz;
    logic                      ovx;
    logic                      ovz;

    always_comb
    begin
        kgain_s  = $signed({1'b0, KGAIN});
        hix      = in_data.x[XW-1:16];
        hiz      = in_data.y[XW-1:16];
        hkx_next = HW'(hix) * HW'(kgain_s);
        hkz_next = HW'(hiz) * HW'(kgain_s);
        lpx      = 48'(in_data.x[15:0]) * 48'(KGAIN);
        lpz      = 48'(in_data.y[15:0]) * 48'(KGAIN);
    end

    always_comb
    begin
        psx  = {hkx_reg[HW-1], hkx_reg} + {{(PW-32){1'b0}}, lkx_reg};
        psz  = {hkz_reg[HW-1], hkz_reg} + {{(PW-32){1'b0}}, lkz_reg};
        rndx = psx + (PW'(1) << (15 + GUARD));
        rndz = psz + (PW'(1) << (15 + GUARD));
    end

    always_comb
    begin
        sx  = {rx_reg[RW-1], rx_reg} + {{(RW+1-COORD_W){px2_reg[COORD_W-1]}}, px2_reg};
        sz  = {rz_reg[RW-1], rz_reg} + {{(RW+1-COORD_W){pz2_reg[COORD_W-1]}}, pz2_reg};
        // fits when all bits above the q16.16 sign agree
        ovx = !((&sx[RW:COORD_W-1]) || !(|sx[RW:COORD_W-1]));
        ovz = !((&sz[RW:COORD_W-1]) || !(|sz[RW:COORD_W-1]));
        if (ovx)
        begin
            res_next.rx = sx[RW] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            res_next.rx = sx[COORD_W-1:0];
        end
        if (ovz)
        begin
            res_next.rz = sz[RW] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            res_next.rz = sz[COORD_W-1:0];
        end
        res_next.clip = ovx | ovz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hkx_reg <= hkx_next;
            hkz_reg <= hkz_next;
            lkx_reg <= lpx[47:16];
            lkz_reg <= lpz[47:16];
            px1_reg <= in_data.px;
            pz1_reg <= in_data.pz;
            rx_reg  <= rndx[PW-1:16+GUARD];
            rz_reg  <= rndz[PW-1:16+GUARD];
            px2_reg <= px1_reg;
            pz2_reg <= pz1_reg;
            res_reg <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = res_reg;

endmodule

// ===== src/prap_out.sv =====
// result register with one-entry skid buffer; drives the pipeline enable
// depends on prap_pkg and the assertion macro header
module prap_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  prap_pkg::res_t                      in_data,
    output logic                                pipe_en,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [prap_pkg::COORD_W-1:0] rotated_x,
    output logic signed [prap_pkg::COORD_W-1:0] rotated_z,
    output logic                                clipped
);
    import prap_pkg::*;

`include "point_rotate_about_pivot_top_macros.svh"

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_data_reg;
    res_t out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_data_reg;
    res_t skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!skid_valid_reg)
        begin
            if (out_valid_reg && res_stall)
            begin
                skid_valid_next = in_valid;
                skid_data_next  = in_data;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (!res_stall)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign pipe_en   = !skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign rotated_x = out_data_reg.rx;
    assign rotated_z = out_data_reg.rz;
    assign clipped   = out_data_reg.clip;

    `PRAP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid holds a result while the output register is empty")
    `PRAP_ASSERT_NEXT(a_skid_holds, skid_valid_reg && res_stall, skid_valid_reg,
        "skid entry lost while the result side stalls")
    `PRAP_ASSERT_NEXT(a_skid_stays_empty, !skid_valid_reg && !(out_valid_reg && res_stall),
        !skid_valid_reg, "skid filled while the result side was free")
    `PRAP_ASSERT_NOW(a_clip_at_limit, out_valid_reg && out_data_reg.clip,
        (out_data_reg.rx == {1'b0, {(COORD_W-1){1'b1}}}) ||
        (out_data_reg.rx == {1'b1, {(COORD_W-1){1'b0}}}) ||
        (out_data_reg.rz == {1'b0, {(COORD_W-1){1'b1}}}) ||
        (out_data_reg.rz == {1'b1, {(COORD_W-1){1'b0}}}),
        "clipped result with neither coordinate at a q16.16 limit")

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for point_rotate_about_pivot_top
// depends on prap_pkg and the rtl under src; needs no files or arguments at run time
module tb_top;

    import prap_pkg::*;

    // cordic depth used for both the dut and the local rotation math
    localparam int STAGES       = ROTATION_STAGES_DEF;
    localparam int GUARD_BITS   = 8;
    localparam longint CORDIC_GAIN = 64'sd2608131496;
    localparam longint ROUND_HALF  = 64'sd1 <<< (15 + GUARD_BITS);
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;
    localparam int LIMIT_CYCLES = 200000;

    // one request as the sender drives it
    typedef struct {
        logic signed [COORD_W-1:0]  pivot_x;
        logic signed [COORD_W-1:0]  pivot_z;
        logic [ANGLE_IN_W-1:0]      turn_angle;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_z;
    } rot_request_t;

    // one rotated point as the dut should return it
    typedef struct {
        logic signed [COORD_W-1:0]  rot_x;
        logic signed [COORD_W-1:0]  rot_z;
        logic                       clip;
    } rot_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       pt_valid;
    logic                       pt_stall;
    logic signed [COORD_W-1:0]  pivot_x;
    logic signed [COORD_W-1:0]  pivot_z;
    logic [ANGLE_IN_W-1:0]      turn_angle;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_z;
    logic                       res_valid;
    logic                       res_stall;
    logic signed [COORD_W-1:0]  rotated_x;
    logic signed [COORD_W-1:0]  rotated_z;
    logic                       clipped;

    // results still owed by the dut, oldest first
    rot_result_t expected_rotations[$];

    int error_count    = 0;
    int cycle_count    = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // arctangent of 2^-i in 2^-32 turn units, rounded to nearest
    longint arctan_steps [32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
        64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
        64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
    };

    point_rotate_about_pivot_top #(
        .ROTATION_STAGES (STAGES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_valid   (pt_valid),
        .pt_stall   (pt_stall),
        .pivot_x    (pivot_x),
        .pivot_z    (pivot_z),
        .turn_angle (turn_angle),
        .point_x    (point_x),
        .point_z    (point_z),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .rotated_x  (rotated_x),
        .rotated_z  (rotated_z),
        .clipped    (clipped)
    );

    // free-running clock, period 12
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // hard stop in case a request or a result never gets through
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_rotations.size());
            $display("** point_rotate_about_pivot_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // rotation math
    // ------------------------------------------------------------------

    // multiply by the cordic gain compensation, split so the product fits
    // in 64 bits; guard bits and the 2^32 scale drop together, half up
    function automatic longint scale_by_gain(input longint v);
        longint hi;
        longint lo;
        longint prod;
        hi = v >>> 16;
        lo = v - hi * 65536;
        prod = hi * CORDIC_GAIN + ((lo * CORDIC_GAIN) >>> 16);
        return (prod + ROUND_HALF) >>> (16 + GUARD_BITS);
    endfunction

    // clamp to q16.16 and flag the clamp
    function automatic logic signed [COORD_W-1:0] clamp_q16(input longint v,
                                                            inout logic hit);
        if (v > Q_MAX)
        begin
            hit = 1'b1;
            return Q_MAX[COORD_W-1:0];
        end
        if (v < Q_MIN)
        begin
            hit = 1'b1;
            return Q_MIN[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    // full rotate-about-pivot: offset, quadrant fold, cordic, gain, re-add
    function automatic rot_result_t rotate_point(input rot_request_t r);
        longint x;
        longint y;
        longint xs;
        longint ys;
        longint resid;
        logic [ANGLE_IN_W-1:0] a;
        logic hit;
        rot_result_t res;
        x = longint'($signed(r.point_x)) - longint'($signed(r.pivot_x));
        y = longint'($signed(r.point_z)) - longint'($signed(r.pivot_z));
        a = r.turn_angle;
        hit = 1'b0;
        // angles in the left half plane: turn the offset by half a turn first
        if (a[15] ^ a[14])
        begin
            x = -x;
            y = -y;
            a = a + 16'd32768;
        end
        resid = longint'($signed(a)) * 65536;
        x = x * (64'sd1 <<< GUARD_BITS);
        y = y * (64'sd1 <<< GUARD_BITS);
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (resid >= 0)
            begin
                x = x - ys;
                y = y + xs;
                resid = resid - arctan_steps[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                resid = resid + arctan_steps[i];
            end
        end
        res.rot_x = clamp_q16(scale_by_gain(x) + longint'($signed(r.pivot_x)), hit);
        res.rot_z = clamp_q16(scale_by_gain(y) + longint'($signed(r.pivot_z)), hit);
        res.clip  = hit;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    function automatic rot_request_t make_request(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] pz,
        input logic [ANGLE_IN_W-1:0]     ang,
        input logic signed [COORD_W-1:0] qx,
        input logic signed [COORD_W-1:0] qz
    );
        rot_request_t r;
        r.pivot_x    = px;
        r.pivot_z    = pz;
        r.turn_angle = ang;
        r.point_x    = qx;
        r.point_z    = qz;
        return r;
    endfunction

    // idles at random, then holds the request until the dut takes it;
    // returns at the accepting edge with valid still high, so the caller
    // must drive valid or a new request before the next edge
    task automatic send_request(input rot_request_t r);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pt_valid <= 1'b0;
            @(posedge clk);
        end
        pt_valid   <= 1'b1;
        pivot_x    <= r.pivot_x;
        pivot_z    <= r.pivot_z;
        turn_angle <= r.turn_angle;
        point_x    <= r.point_x;
        point_z    <= r.point_z;
        @(posedge clk);
        while (pt_stall)
        begin
            @(posedge clk);
        end
        expected_rotations = {expected_rotations, rotate_point(r)};
    endtask

    // sender goes quiet until every outstanding result is back
    task automatic wait_for_results();
        pt_valid <= 1'b0;
        while (expected_rotations.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stall and in-order compare
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        error_count++;
        $display("%0t mismatch %s: expected %0d actual %0d",
                 $time, field, want, got);
    endtask

    initial
    begin
        rot_result_t want;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (expected_rotations.size() == 0)
                begin
                    error_count++;
                    $display("%0t result with no request: x %0d z %0d clip %0b",
                             $time, rotated_x, rotated_z, clipped);
                end
                else
                begin
                    want = expected_rotations.pop_front();
                    if (rotated_x !== want.rot_x)
                    begin
                        report_mismatch("rotated_x", want.rot_x, rotated_x);
                    end
                    if (rotated_z !== want.rot_z)
                    begin
                        report_mismatch("rotated_z", want.rot_z, rotated_z);
                    end
                    if (clipped !== want.clip)
                    begin
                        report_mismatch("clipped", want.clip, clipped);
                    end
                end
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a fixed offset swept through every quadrant and its boundaries
    task automatic test_quadrant_angles();
        logic [ANGLE_IN_W-1:0] sweep [12];
        sweep = '{16'd0, 16'd1, 16'd8192, 16'd16383, 16'd16384, 16'd16385,
                  16'd32767, 16'd32768, 16'd49151, 16'd49152, 16'd49153,
                  16'd65535};
        foreach (sweep[k])
        begin
            send_request(make_request(32'sh0003_8000, -32'sh0002_4000, sweep[k],
                                      32'sh000D_8000, 32'sh0004_C000));
        end
    endtask

    // field extremes, zero offsets and both directions of saturation
    task automatic test_extremes_and_clipping();
        localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        send_request(make_request(32'sd0, 32'sd0, 16'd0, 32'sd0, 32'sd0));
        send_request(make_request(-32'sd1, -32'sd1, 16'hFFFF, -32'sd1, -32'sd1));
        // largest offsets, no rotation
        send_request(make_request(MINV, MINV, 16'd0, MAXV, MAXV));
        // largest offsets flipped: both coordinates clamp low
        send_request(make_request(MINV, MINV, 16'd32768, MAXV, MAXV));
        // same the other way: both clamp high
        send_request(make_request(MAXV, MAXV, 16'd32768, MINV, MINV));
        // 45 degrees about the origin grows one coordinate past the range
        send_request(make_request(32'sd0, 32'sd0, 16'd8192, MAXV, MINV));
        send_request(make_request(MAXV, MINV, 16'd16384, MINV, MAXV));
        // point on the pivot stays put at any angle
        send_request(make_request(MAXV, MAXV, 16'd12345, MAXV, MAXV));
        send_request(make_request(MAXV, MINV, 16'd49152, MINV, MAXV));
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $signed($urandom_range(2097151)) - 32'sd1048576;
            2: v = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(65535)
                                     : 32'sh8000_0000 + $urandom_range(65535);
            default: v = ($signed($urandom_range(2000)) - 32'sd1000) <<< 16;
        endcase
        return v;
    endfunction

    // random requests under one idling mix, then a full drain
    task automatic test_random_stream(input int count, input int send_idle,
                                      input int recv_idle);
        rot_request_t r;
        sender_idle_pct = send_idle;
        recv_stall_pct  = recv_idle;
        for (int n = 0; n < count; n++)
        begin
            r.pivot_x = random_coord();
            r.pivot_z = random_coord();
            // angles near the quadrant edges are where the fold switches
            if ($urandom_range(3) == 0)
            begin
                r.turn_angle = 16'($urandom_range(3) * 16384 + $urandom_range(4) - 2);
            end
            else
            begin
                r.turn_angle = 16'($urandom_range(65535));
            end
            // points often sit near their pivot, sometimes anywhere
            if ($urandom_range(1))
            begin
                r.point_x = r.pivot_x + random_coord();
                r.point_z = r.pivot_z + random_coord();
            end
            else
            begin
                r.point_x = random_coord();
                r.point_z = random_coord();
            end
            send_request(r);
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // main flow
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        pt_valid   <= 1'b0;
        pivot_x    <= '0;
        pivot_z    <= '0;
        turn_angle <= '0;
        point_x    <= '0;
        point_z    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with light idling on both sides
        sender_idle_pct = 20;
        recv_stall_pct  = 20;
        test_quadrant_angles();
        test_extremes_and_clipping();
        wait_for_results();

        // random part: receiver stalls more, then sender idles more, then neither
        test_random_stream(400, 38, 67);
        test_random_stream(400, 67, 38);
        test_random_stream(400, 0, 0);

        // let any stray result show up before the verdict
        wait_for_results();
        repeat (STAGES + 10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("** point_rotate_about_pivot_top: PASSED **");
        end
        else
        begin
            $display("** point_rotate_about_pivot_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== point_rotate_about_pivot_top.f =====
+incdir+src
src/prap_pkg.sv
src/prap_prep.sv
src/prap_cell.sv
src/prap_gain.sv
src/prap_out.sv
src/point_rotate_about_pivot_top.sv
verif/tb_top.sv
